[rtl/core/plasma_density_profile_2d_core_defines.svh]
// Assertion helpers for the density profile core
`ifndef PLASMA_DENSITY_PROFILE_2D_CORE_DEFINES_SVH
`define PLASMA_DENSITY_PROFILE_2D_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PDP2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PDP2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pdp2d_pkg.sv]
package pdp2d_pkg;

  localparam int POS_W  = 20;
  localparam int QB     = 23;            // quotient bits of the divider
  localparam int NUM_W  = POS_W + QB;
  localparam int DIV_ST = QB;
  localparam int PWR_ST = 15;
  localparam int LAT    = 45;            // valid pipe depth, accept edge to result edge

  localparam logic [15:0] ONE16 = 16'h8000;
  localparam logic [15:0] LO    = 16'd6554;
  localparam logic [15:0] SPAN  = 16'd26214;
  localparam logic [22:0] T_CAP = 23'h400000;
  localparam logic [22:0] R_ONE = 23'h010000;
  localparam logic [3:0]  MAX_ORDER = 4'd15;

  localparam logic [63:0] TWO_PI_Q32 = 64'd26986075410;
  localparam logic [19:0] B2   = 20'((64'd2   * TWO_PI_Q32 + 64'd2097152) >> 22);
  localparam logic [19:0] B13  = 20'((64'd13  * TWO_PI_Q32 + 64'd2097152) >> 22);
  localparam logic [19:0] B20  = 20'((64'd20  * TWO_PI_Q32 + 64'd2097152) >> 22);
  localparam logic [19:0] B65  = 20'((64'd65  * TWO_PI_Q32 + 64'd2097152) >> 22);
  localparam logic [19:0] B82  = 20'((64'd82  * TWO_PI_Q32 + 64'd2097152) >> 22);
  localparam logic [19:0] B112 = 20'((64'd112 * TWO_PI_Q32 + 64'd2097152) >> 22);
  localparam logic [19:0] D13  = B20 - B13;
  localparam logic [19:0] D65  = B82 - B65;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_XVAC   = 3'd1;
  localparam logic [2:0] REG_XLEN   = 3'd2;
  localparam logic [2:0] REG_YVAC   = 3'd3;
  localparam logic [2:0] REG_YLEN   = 3'd4;
  localparam logic [2:0] REG_ORDERS = 3'd5;

  typedef enum logic [1:0] {MD_BOX, MD_TRAP, MD_GAUSS, MD_FIXED} mode_t;
  typedef enum logic [1:0] {KD_CONST, KD_ADD, KD_SUB, KD_GAUSS} kind_t;
  typedef enum logic [1:0] {NT_ZERO, NT_SH15, NT_SH17, NT_SPAN} ntype_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] base;
    logic        fault;
    logic        sat;
  } side_t;

  // 2^-(k/16) in Q16
  function automatic logic [16:0] exp2_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/pdp2d_axis.sv]
module pdp2d_axis (
  input  logic                clk,
  input  logic [19:0]         p_i,
  input  pdp2d_pkg::mode_t    mode_i,
  input  logic [19:0]         vac_i,
  input  logic [59:0]         lens_i,
  input  logic [3:0]          order_i,
  input  logic                flat_i,
  output logic [15:0]         factor_o,
  output logic                fault_o
);
  import pdp2d_pkg::*;

  logic [19:0] plat, left, right;
  logic [21:0] pe, vac22, a22, b22, c22;
  logic [20:0] wend;
  logic [19:0] ad;
  logic [3:0]  n_ord;

  side_t       side_a;
  ntype_t      nt_a;
  logic [19:0] diff_a, dv_a;

  side_t       side_b_r;
  ntype_t      nt_b_r;
  logic [19:0] diff_b_r, dv_b_r;
  logic [35:0] span_prod;
  logic [NUM_W-1:0] num_b;

  logic [19:0]   rem_r  [0:DIV_ST];
  logic [QB-1:0] low_r  [0:DIV_ST];
  logic [QB-1:0] quo_r  [0:DIV_ST];
  logic [19:0]   dv_r   [0:DIV_ST];
  side_t         sd_r   [0:DIV_ST];

  logic [22:0] t_r   [0:PWR_ST];
  logic [22:0] r_r   [0:PWR_ST];
  side_t       ps_r  [0:PWR_ST];
  logic [15:0] val_r [0:PWR_ST];

  logic [22:0] q_fin;
  logic [22:0] r_nxt;
  logic [15:0] val_nxt;

  logic [16:0] e_tk_r;
  logic [11:0] e_sub_r;
  logic [6:0]  e_i_r;
  side_t       e_side_r;
  logic [15:0] e_val_r;
  logic [16:0] tk0, tk1, tdl;
  logic [23:0] iprod;
  logic [16:0] v2;
  logic [15:0] fac;

  assign plat  = lens_i[19:0];
  assign left  = lens_i[39:20];
  assign right = lens_i[59:40];
  assign pe    = {2'b00, p_i};
  assign vac22 = {2'b00, vac_i};
  assign a22   = vac22 + {2'b00, left};
  assign b22   = a22 + {2'b00, plat};
  assign c22   = b22 + {2'b00, right};
  assign wend  = {1'b0, vac_i} + {1'b0, plat};
  assign ad    = (p_i < right) ? right - p_i : p_i - right;
  assign n_ord = (order_i > MAX_ORDER) ? MAX_ORDER : order_i;

  // region decode and divider set-up
  always_comb begin
    side_a = '{kind: KD_CONST, base: 16'd0, fault: 1'b0, sat: 1'b0};
    nt_a   = NT_ZERO;
    diff_a = 20'd0;
    dv_a   = 20'd1;
    case (mode_i)
      MD_BOX: begin
        if (p_i > vac_i && {1'b0, p_i} < wend) side_a.base = ONE16;
      end
      MD_TRAP: begin
        if (pe < vac22) begin
          side_a.base = 16'd0;
        end else if (pe < a22) begin
          side_a.kind = KD_ADD;
          nt_a   = NT_SH15;
          diff_a = p_i - vac_i;
          dv_a   = left;
        end else if (pe < b22) begin
          side_a.base = ONE16;
        end else if (pe < c22) begin
          side_a.kind = KD_SUB;
          side_a.base = ONE16;
          nt_a   = NT_SH15;
          diff_a = 20'(pe - b22);
          dv_a   = right;
        end
      end
      MD_GAUSS: begin
        if (flat_i) begin
          side_a.base = ONE16;
        end else if (left == 20'd0) begin
          side_a.fault = 1'b1;
        end else if (p_i < vac_i || {1'b0, p_i} >= wend) begin
          side_a.base = 16'd0;
        end else if (p_i < right && n_ord[0]) begin
          // negative exponent saturates
          side_a.base = ONE16;
        end else begin
          side_a.kind = KD_GAUSS;
          side_a.sat  = {6'd0, ad} >= {left, 6'd0};
          nt_a   = NT_SH17;
          diff_a = ad;
          dv_a   = left;
        end
      end
      default: begin
        if (p_i < B2) begin
          side_a.base = 16'd0;
        end else if (p_i < B13) begin
          side_a.base = LO;
        end else if (p_i < B20) begin
          side_a.kind = KD_ADD;
          side_a.base = LO;
          nt_a   = NT_SPAN;
          diff_a = p_i - B13;
          dv_a   = D13;
        end else if (p_i < B65) begin
          side_a.base = ONE16;
        end else if (p_i < B82) begin
          side_a.kind = KD_SUB;
          side_a.base = ONE16;
          nt_a   = NT_SPAN;
          diff_a = p_i - B65;
          dv_a   = D65;
        end else if (p_i < B112) begin
          side_a.base = LO;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    side_b_r <= side_a;
    nt_b_r   <= nt_a;
    diff_b_r <= diff_a;
    dv_b_r   <= dv_a;
  end

  assign span_prod = {16'd0, diff_b_r} * {20'd0, SPAN};

  always_comb begin
    case (nt_b_r)
      NT_SH15: num_b = {8'd0, diff_b_r, 15'd0};
      NT_SH17: num_b = {6'd0, diff_b_r, 17'd0};
      NT_SPAN: num_b = {7'd0, span_prod};
      default: num_b = '0;
    endcase
    if (side_b_r.sat) num_b = '0;
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= num_b[NUM_W-1:QB];
    low_r[0] <= num_b[QB-1:0];
    quo_r[0] <= '0;
    dv_r[0]  <= dv_b_r;
    sd_r[0]  <= side_b_r;
  end

  // restoring divider, one quotient bit per stage
  for (genvar g = 1; g <= DIV_ST; g++) begin : g_div
    logic [20:0] tr;
    logic        ge;
    assign tr = {rem_r[g-1], low_r[g-1][QB-1]};
    assign ge = tr >= {1'b0, dv_r[g-1]};
    always_ff @(posedge clk) begin
      rem_r[g] <= ge ? 20'(tr - {1'b0, dv_r[g-1]}) : tr[19:0];
      low_r[g] <= {low_r[g-1][QB-2:0], 1'b0};
      quo_r[g] <= {quo_r[g-1][QB-2:0], ge};
      dv_r[g]  <= dv_r[g-1];
      sd_r[g]  <= sd_r[g-1];
    end
  end

  assign q_fin = quo_r[DIV_ST];

  always_comb begin
    r_nxt = (sd_r[DIV_ST].sat || q_fin > T_CAP) ? T_CAP : q_fin;
    case (sd_r[DIV_ST].kind)
      KD_ADD:  val_nxt = sd_r[DIV_ST].base + q_fin[15:0];
      KD_SUB:  val_nxt = sd_r[DIV_ST].base - q_fin[15:0];
      default: val_nxt = sd_r[DIV_ST].base;
    endcase
  end

  always_ff @(posedge clk) begin
    t_r[0]   <= R_ONE;
    r_r[0]   <= r_nxt;
    ps_r[0]  <= sd_r[DIV_ST];
    val_r[0] <= val_nxt;
  end

  // t = r^n, one multiply per stage
  for (genvar g = 1; g <= PWR_ST; g++) begin : g_pwr
    logic [45:0] m;
    logic [22:0] tc;
    assign m  = {23'd0, t_r[g-1]} * {23'd0, r_r[g-1]};
    assign tc = (m[45:16] > {7'd0, T_CAP}) ? T_CAP : m[38:16];
    always_ff @(posedge clk) begin
      t_r[g]   <= (ps_r[g-1].kind == KD_GAUSS && 4'(g - 1) < n_ord) ? tc : t_r[g-1];
      r_r[g]   <= r_r[g-1];
      ps_r[g]  <= ps_r[g-1];
      val_r[g] <= val_r[g-1];
    end
  end

  assign tk0   = exp2_tab({1'b0, t_r[PWR_ST][15:12]});
  assign tk1   = exp2_tab({1'b0, t_r[PWR_ST][15:12]} + 5'd1);
  assign tdl   = tk0 - tk1;
  assign iprod = {12'd0, tdl[11:0]} * {12'd0, t_r[PWR_ST][11:0]};

  always_ff @(posedge clk) begin
    e_tk_r   <= tk0;
    e_sub_r  <= iprod[23:12];
    e_i_r    <= t_r[PWR_ST][22:16];
    e_side_r <= ps_r[PWR_ST];
    e_val_r  <= val_r[PWR_ST];
  end

  assign v2  = e_tk_r - {5'd0, e_sub_r};
  assign fac = 16'((v2 >> 1) >> e_i_r);

  always_ff @(posedge clk) begin
    factor_o <= (e_side_r.kind == KD_GAUSS) ? fac : e_val_r;
    fault_o  <= e_side_r.fault;
  end

endmodule

[rtl/core/plasma_density_profile_2d_core.sv]
// out_valid is the end of the valid pipeline, which runs beside the input, axis and density registers.
// Throughput: one word per cycle; busy stays low, so start may be held high.
// The depth is set by the 23-stage divider and the 15-stage power chain.
// Reset (rst_n low, synchronous) sets the configuration registers (order to 2) and clears the valid pipeline.
// The receiver cannot stall: each result shows for one cycle only.
`include "plasma_density_profile_2d_core_defines.svh"

module plasma_density_profile_2d_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_pos_x,
  input  logic [19:0] in_pos_y,
  output logic        out_valid,
  output logic [15:0] out_density,
  output logic        out_width_fault,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [59:0] cfg_data
);
  import pdp2d_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [19:0] xvac_r, xvac_nxt, yvac_r, yvac_nxt;
  logic [59:0] xlen_r, xlen_nxt, ylen_r, ylen_nxt;
  logic [7:0]  ord_r, ord_nxt;

  logic [LAT-1:0] vld_r, vld_nxt;
  logic [19:0] px_r, py_r;
  logic [15:0] fx, fy;
  logic        flt_x, flt_y;
  logic [31:0] prod;
  logic [15:0] den_r;
  logic        flt_r;

  assign busy = 1'b0;

  always_comb begin
    mode_nxt = mode_r;
    xvac_nxt = xvac_r;
    xlen_nxt = xlen_r;
    yvac_nxt = yvac_r;
    ylen_nxt = ylen_r;
    ord_nxt  = ord_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_nxt = mode_t'(cfg_data[1:0]);
        REG_XVAC:   xvac_nxt = cfg_data[19:0];
        REG_XLEN:   xlen_nxt = cfg_data;
        REG_YVAC:   yvac_nxt = cfg_data[19:0];
        REG_YLEN:   ylen_nxt = cfg_data;
        REG_ORDERS: ord_nxt  = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MD_BOX;
      xvac_r <= '0;
      xlen_r <= '0;
      yvac_r <= '0;
      ylen_r <= '0;
      ord_r  <= 8'd2;
      vld_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      xvac_r <= xvac_nxt;
      xlen_r <= xlen_nxt;
      yvac_r <= yvac_nxt;
      ylen_r <= ylen_nxt;
      ord_r  <= ord_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= in_pos_x;
    py_r <= in_pos_y;
  end

  pdp2d_axis u_axis_x (
    .clk      (clk),
    .p_i      (px_r),
    .mode_i   (mode_r),
    .vac_i    (xvac_r),
    .lens_i   (xlen_r),
    .order_i  (ord_r[3:0]),
    .flat_i   (1'b0),
    .factor_o (fx),
    .fault_o  (flt_x)
  );

  // y order of zero gives a flat y axis in gaussian mode
  pdp2d_axis u_axis_y (
    .clk      (clk),
    .p_i      (py_r),
    .mode_i   (mode_r),
    .vac_i    (yvac_r),
    .lens_i   (ylen_r),
    .order_i  (ord_r[7:4]),
    .flat_i   (mode_r == MD_GAUSS && ord_r[7:4] == 4'd0),
    .factor_o (fy),
    .fault_o  (flt_y)
  );

  // fixed mode has a flat y axis
  assign prod = {16'd0, fx} * {16'd0, (mode_r == MD_FIXED) ? ONE16 : fy};

  always_ff @(posedge clk) begin
    den_r <= prod[30:15];
    flt_r <= flt_x | flt_y;
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_density     = den_r;
  assign out_width_fault = flt_r;

  `PDP2D_ASSERT_NOW(a_den_le_one, out_valid, out_density <= ONE16, "density above 1.0")
  `PDP2D_ASSERT_NOW(a_fault_gauss, out_valid && out_width_fault, mode_r == MD_GAUSS, "fault outside gaussian mode")
  `PDP2D_ASSERT_NOW(a_box_binary, out_valid && mode_r == MD_BOX, out_density == 16'd0 || out_density == ONE16, "box density not 0 or 1.0")
  `PDP2D_ASSERT_NEXT(a_accept_tracked, start && !busy, vld_r[0], "accepted word not tracked")

endmodule
